// ----- rtl/core/gwm_pkg.sv -----
// package for the wildcard glob matcher: input modes, pattern codes and cell link types
// no dependencies
package gwm_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_SUBJECT = 2'd2,
        MODE_END     = 2'd3
    } mode_t;

    localparam logic [7:0] STAR_CODE  = 8'd42;
    localparam logic [7:0] QMARK_CODE = 8'd63;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic       clear;
        logic       load;
        logic       step;
        logic       fresh;
        logic [7:0] char_code;
    } ctrl_t;

    // handed from one cell to its right-hand neighbor
    typedef struct packed {
        logic start;
        logic match;
        logic carry;
        logic filled;
        logic hit;
    } link_t;

endpackage

// ----- rtl/core/gwm_req_if.sv -----
// request channel of the glob matcher: mode and character of one input item
// no dependencies
interface gwm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] char_code;

    modport source (output valid, output mode, output char_code, input ready);
    modport sink (input valid, input mode, input char_code, output ready);
endinterface

// ----- rtl/core/gwm_rsp_if.sv -----
// result channel of the glob matcher: match verdict and overflow flag of one item
// no dependencies
interface gwm_rsp_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ----- rtl/core/gwm_cell.sv -----
// one pattern position of the glob matcher: stored character, fill bit, active bit
// depends on gwm_pkg
module gwm_cell
    import gwm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctrl,
    input  link_t left,
    output link_t right
);

    logic [7:0] char_reg;
    logic       filled_reg;
    logic       act_reg;
    logic       act_next;
    logic       is_star;
    logic       eff;
    logic       live;

    always_comb
    begin
        is_star      = (char_reg == STAR_CODE);
        eff          = ctrl.fresh ? left.start : act_reg;
        live         = eff & filled_reg;
        act_next     = (live & is_star) | left.match | left.carry;
        right.start  = left.start & filled_reg & is_star;
        right.match  = live & ~is_star &
                       ((char_reg == QMARK_CODE) | (char_reg == ctrl.char_code));
        right.carry  = act_next & filled_reg & is_star;
        right.filled = filled_reg;
        right.hit    = left.hit | (eff & left.filled & ~filled_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            act_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                filled_reg <= 1'b0;
            end
            else if (ctrl.load && left.filled && !filled_reg)
            begin
                filled_reg <= 1'b1;
            end
            if (ctrl.step)
            begin
                act_reg <= act_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && left.filled && !filled_reg)
        begin
            char_reg <= ctrl.char_code;
        end
    end

endmodule

// ----- rtl/core/wildcard_glob_matcher_unit.sv -----
// glob matcher top level: a row of PAT_MAX pattern cells plus the final position
// depends on gwm_pkg, gwm_req_if, gwm_rsp_if and gwm_cell
// throughput: one item per cycle of any mode unless an unread result fills the output register;
// each subject byte ripples once along the cell row; an end-of-subject item gives its result in
// the output register in the cycle after it is accepted
// reset: asynchronous active low; empty pattern, no overflow, only the start position active
module wildcard_glob_matcher_unit
    import gwm_pkg::*;
#(
    parameter int PAT_MAX = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    gwm_req_if.sink   req,
    gwm_rsp_if.source rsp
);

    ctrl_t ctrl;
    link_t link [0:PAT_MAX];
    mode_t mode;
    logic  accept;
    logic  fresh_reg;
    logic  fresh_next;
    logic  ovf_reg;
    logic  ovf_next;
    logic  act_end_reg;
    logic  eff_end;
    logic  hit;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  matched_reg;
    logic  out_ovf_reg;

    assign req.ready = ~out_valid_reg | rsp.ready;
    assign accept    = req.valid & req.ready;
    assign mode      = mode_t'(req.mode);

    assign link[0] = '{start: 1'b1, match: 1'b0, carry: 1'b0, filled: 1'b1, hit: 1'b0};

    for (genvar i = 0; i < PAT_MAX; i++)
    begin : g_cell
        gwm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (link[i]),
            .right (link[i + 1])
        );
    end

    always_comb
    begin
        ctrl.clear     = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.step      = 1'b0;
        ctrl.fresh     = fresh_reg;
        ctrl.char_code = req.char_code;
        fresh_next     = fresh_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        eff_end        = fresh_reg ? link[PAT_MAX].start : act_end_reg;
        hit            = link[PAT_MAX].hit | (eff_end & link[PAT_MAX].filled);
        if (accept)
        begin
            unique case (mode)
                MODE_CLEAR:
                begin
                    ctrl.clear = 1'b1;
                    fresh_next = 1'b1;
                    ovf_next   = 1'b0;
                end
                MODE_APPEND:
                begin
                    ctrl.load  = 1'b1;
                    fresh_next = 1'b1;
                    if (link[PAT_MAX].filled)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                MODE_SUBJECT:
                begin
                    ctrl.step  = 1'b1;
                    fresh_next = 1'b0;
                end
                MODE_END:
                begin
                    fresh_next     = 1'b1;
                    out_valid_next = 1'b1;
                end
                default:
                begin
                    fresh_next = fresh_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= 1'b1;
            ovf_reg       <= 1'b0;
            act_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg     <= fresh_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (ctrl.step)
            begin
                act_end_reg <= link[PAT_MAX].match | link[PAT_MAX].carry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_END)
        begin
            matched_reg <= hit & ~ovf_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.matched          = matched_reg;
    assign rsp.pattern_overflow = out_ovf_reg;

    a_ovf_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> link[PAT_MAX].filled)
        else $error("overflow set while the pattern row is not full");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_END) |=> (fresh_reg && out_valid_reg))
        else $error("end of subject did not restart or give a result");

    a_match_excludes_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(matched_reg && out_ovf_reg))
        else $error("match reported together with overflow");

    a_subject_clears_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_SUBJECT) |=> !fresh_reg)
        else $error("subject byte left the start state in place");

endmodule
